// ----- rtl/glyph_coverage_pixel_blend_defines.svh -----
// Assertion macros used by the checker of the glyph blender.
`ifndef GLYPH_COVERAGE_PIXEL_BLEND_DEFINES_SVH
`define GLYPH_COVERAGE_PIXEL_BLEND_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define GCPB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked after the delay given by dly.
`define GCPB_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- rtl/gcpb_pkg.sv -----
package gcpb_pkg;

  // One input word: coverage sample and the framebuffer pixel under it.
  typedef struct packed {
    logic [7:0]  coverage;
    logic [31:0] background;
  } in_t;

  // One result word: blended bytes in memory order and how many are valid.
  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [2:0]  byte_count;
  } out_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR      = 2'd0,
    REG_ALPHA_PERCENT = 2'd1,
    REG_PIXEL_FORMAT  = 2'd2,
    REG_BIG_ENDIAN    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_RGB888X  = 2'd2,
    FMT_RESERVED = 2'd3
  } pix_fmt_t;

  localparam logic [6:0] ALPHA_RESET = 7'd100;
  localparam logic [7:0] FULL_SCALE  = 8'hff;
  localparam logic [7:0] MASK_5BIT   = 8'hf8;
  localparam logic [7:0] MASK_6BIT   = 8'hfc;

  // floor(p / 100) for p < 2^15 is (p * 5243) >> 19.
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          RECIP_SHFT = 19;

  localparam logic [2:0] COUNT_2 = 3'd2;
  localparam logic [2:0] COUNT_3 = 3'd3;
  localparam logic [2:0] COUNT_4 = 3'd4;

  // floor(x / 255) for any x up to 255 * 255, the largest channel product.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ----- rtl/glyph_coverage_pixel_blend.sv -----
// Glyph coverage pixel blender.
//
// Input channel: a word (coverage byte plus the existing framebuffer pixel) is
// taken at every rising edge where start is high and busy is low. Busy never
// rises, so the block can take one word in every clock cycle.
// Result channel: each blended pixel appears on out_data for exactly one cycle
// with out_strobe high, after passing every register stage. Results leave in
// the order their words arrived, one per word. The receiver cannot stall, so
// the pipeline never holds; every stage simply advances each cycle.
// Pipeline: alpha times coverage, scaling by 1/100 through a reciprocal
// multiply, the six channel products, the divisions by 255 and channel sums,
// and finally packing and byte ordering into the output register. These five
// register stages make up the whole pipeline.
// Configuration: a plain write port; fg_color, alpha_percent, pixel_format and
// big_endian are for the user to write when the block is idle; it is not enforced.
// Reset (synchronous, active low) clears all valid bits and returns the
// registers to black foreground, 100 percent opacity, RGB565, little endian.
module glyph_coverage_pixel_blend (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  gcpb_pkg::in_t                   in_data,
  output logic                            out_strobe,
  output gcpb_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [gcpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcpb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gcpb_pkg::*;

  // Configuration registers.
  logic [23:0] fg_color_r;
  logic [6:0]  alpha_r;
  logic [1:0]  fmt_r;
  logic        big_endian_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r   <= '0;
      alpha_r      <= ALPHA_RESET;
      fmt_r        <= FMT_RGB565;
      big_endian_r <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FG_COLOR:      fg_color_r   <= cfg_data[23:0];
        REG_ALPHA_PERCENT: alpha_r      <= cfg_data[6:0];
        REG_PIXEL_FORMAT:  fmt_r        <= cfg_data[1:0];
        REG_BIG_ENDIAN:    big_endian_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds, so a word is taken whenever start is high.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: scaled coverage before the division by 100.
  logic        s1_valid_r;
  logic [14:0] s1_prod_r;
  logic [23:0] s1_bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= {8'd0, alpha_r} * {7'd0, in_data.coverage};
    s1_bg_r   <= in_data.background[23:0];
  end

  // Stage 2: v = prod / 100 saturated to 255, background unpacked to 8-bit channels.
  logic        s2_valid_r;
  logic [7:0]  s2_v_r;
  logic [2:0][7:0] s2_bg_r;
  logic [2:0][7:0] s2_bg_nxt;
  logic [27:0] v_wide;
  logic [8:0]  v_full;
  logic [7:0]  v_sat;

  always_comb begin
    v_wide = {13'd0, s1_prod_r} * {15'd0, RECIP_100};
    v_full = v_wide[RECIP_SHFT +: 9];
    v_sat  = v_full[8] ? FULL_SCALE : v_full[7:0];
    if (fmt_r == FMT_RGB565) begin
      s2_bg_nxt[2] = s1_bg_r[15:8] & MASK_5BIT;
      s2_bg_nxt[1] = s1_bg_r[10:3] & MASK_6BIT;
      s2_bg_nxt[0] = {s1_bg_r[4:0], 3'b000} & MASK_5BIT;
    end else begin
      s2_bg_nxt[2] = s1_bg_r[23:16];
      s2_bg_nxt[1] = s1_bg_r[15:8];
      s2_bg_nxt[0] = s1_bg_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_v_r  <= v_sat;
    s2_bg_r <= s2_bg_nxt;
  end

  // Stage 3: foreground and background products for each channel.
  logic             s3_valid_r;
  logic [2:0][15:0] s3_fg_prod_r;
  logic [2:0][15:0] s3_bg_prod_r;
  logic [7:0]       inv_v;

  assign inv_v = FULL_SCALE - s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s3_fg_prod_r[c] <= {8'd0, fg_color_r[8*c +: 8]} * {8'd0, s2_v_r};
      s3_bg_prod_r[c] <= {8'd0, s2_bg_r[c]} * {8'd0, inv_v};
    end
  end

  // Stage 4: each product divided by 255 and the two parts summed.
  // The sum never exceeds 255.
  logic            s4_valid_r;
  logic [2:0][7:0] s4_ch_r;
  logic [2:0][8:0] ch_sum;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_sum[c] = {1'b0, div255(s3_fg_prod_r[c])} + {1'b0, div255(s3_bg_prod_r[c])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s4_ch_r[c] <= ch_sum[c][7:0];
    end
  end

  // Stage 5: packing and byte order into the output register.
  logic        out_strobe_r;
  out_t        out_data_r;
  out_t        out_data_nxt;
  logic [7:0]  red;
  logic [7:0]  grn;
  logic [7:0]  blu;
  logic [15:0] w565;

  always_comb begin
    red  = s4_ch_r[2];
    grn  = s4_ch_r[1];
    blu  = s4_ch_r[0];
    w565 = {red[7:3], grn[7:2], blu[7:3]};
    case (pix_fmt_t'(fmt_r))
      FMT_RGB565: begin
        out_data_nxt.byte_count  = COUNT_2;
        out_data_nxt.pixel_bytes = big_endian_r ? {16'd0, w565[7:0], w565[15:8]}
                                                : {16'd0, w565};
      end
      FMT_RGB888: begin
        out_data_nxt.byte_count  = COUNT_3;
        out_data_nxt.pixel_bytes = big_endian_r ? {8'd0, blu, grn, red}
                                                : {8'd0, red, grn, blu};
      end
      default: begin
        // Four-byte format; the unused format code behaves the same way.
        out_data_nxt.byte_count  = COUNT_4;
        out_data_nxt.pixel_bytes = big_endian_r ? {blu, grn, red, 8'd0}
                                                : {8'd0, red, grn, blu};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- rtl/gcpb_checker.sv -----
`include "glyph_coverage_pixel_blend_defines.svh"

module gcpb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input gcpb_pkg::out_t out_data
);
  import gcpb_pkg::*;

  logic count_ok;
  logic upper_zero;

  assign count_ok = (out_data.byte_count == COUNT_2) || (out_data.byte_count == COUNT_3) ||
                    (out_data.byte_count == COUNT_4);
  assign upper_zero = (out_data.byte_count == COUNT_4) ||
                      ((out_data.pixel_bytes[31:24] == 8'd0) &&
                       (out_data.byte_count == COUNT_3 ||
                        out_data.pixel_bytes[23:16] == 8'd0));

  // Every word taken gives a result with out_strobe high.
  `GCPB_ASSERT_DELAY(a_latency, start && !busy, 5, out_strobe, "no result for accepted word")

  // No result appears without a word taken for it.
  `GCPB_ASSERT_IMPL(a_no_extra, out_strobe, $past(start && !busy, 5), "result without a word")

  // The byte count is one of the three pixel sizes.
  `GCPB_ASSERT_IMPL(a_count, out_strobe, count_ok, "bad byte count")

  // Bytes beyond the valid count are zero.
  `GCPB_ASSERT_IMPL(a_upper_zero, out_strobe, upper_zero, "nonzero byte beyond count")

endmodule

bind glyph_coverage_pixel_blend gcpb_checker u_gcpb_checker (.*);
